FILE: sv/pdfm_pkg.sv
// Shared types and constants for the PWM duty and frequency meter.
// No dependencies; every other file imports this package.
package pdfm_pkg;

   localparam int RATE_W          = 27;
   localparam int DUTY_W          = 7;
   localparam int OUT_W           = 32;
   localparam int PERIOD_W        = OUT_W + 1;
   // 100 * (2^32 - 1) stays below 2^39
   localparam int DUTY_DIVIDEND_W = OUT_W + 7;
   localparam int TRIPLE_W        = OUT_W + 2;

   localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000000);

   typedef enum logic [1:0] {
      PHASE_WAIT = 2'd0,
      PHASE_HIGH = 2'd1,
      PHASE_LOW  = 2'd2
   } pdfm_phase_type;

   typedef enum logic [2:0] {
      CTL_IDLE   = 3'd0,
      CTL_SUM    = 3'd1,
      CTL_SCALE  = 3'd2,
      CTL_DIVIDE = 3'd3,
      CTL_SEND   = 3'd4
   } pdfm_ctl_type;

   typedef struct packed {
      logic             emit;
      logic [OUT_W-1:0] high_ticks;
      logic [OUT_W-1:0] low_ticks;
      logic             saturated;
   } pdfm_launch_type;

endpackage

FILE: sv/pdfm_channels.sv
// Request and response channel interfaces of the meter.
// Depends on pdfm_pkg for the field widths.
interface pdfm_req_if import pdfm_pkg::*; ();
   logic valid;
   logic ready;
   logic pin_level;

   modport source (output valid, output pin_level, input ready);
   modport sink   (input valid, input pin_level, output ready);
endinterface

interface pdfm_rsp_if import pdfm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DUTY_W-1:0] duty_percent;
   logic [RATE_W-1:0] frequency_hz;
   logic [OUT_W-1:0]  high_ticks;
   logic [OUT_W-1:0]  low_ticks;
   logic              count_saturated;

   modport source (output valid, output duty_percent, output frequency_hz,
                   output high_ticks, output low_ticks, output count_saturated,
                   input ready);
   modport sink   (input valid, input duty_percent, input frequency_hz,
                   input high_ticks, input low_ticks, input count_saturated,
                   output ready);
endinterface

FILE: sv/pdfm_edge_counter.sv
// Edge detector and saturating high/low tick counters of the meter.
// Depends on pdfm_pkg; hands a closed measurement to the top level.
module pdfm_edge_counter
   import pdfm_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic            pin_level,
   output logic            phase_low,
   output pdfm_launch_type launch
);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

   pdfm_phase_type         phase_ff, phase_in;
   logic                   prev_level_ff, prev_level_in;
   logic [COUNT_WIDTH-1:0] high_count_ff, high_count_in;
   logic [COUNT_WIDTH-1:0] low_count_ff, low_count_in;
   logic                   mark_ff, mark_in;
   logic [COUNT_WIDTH-1:0] high_bump, low_bump;
   logic                   high_over, low_over;
   logic [OUT_W-1:0]       high_out, low_out;

   assign high_bump = (high_count_ff != COUNT_MAX) ? high_count_ff + COUNT_ONE : high_count_ff;
   assign low_bump  = (low_count_ff != COUNT_MAX) ? low_count_ff + COUNT_ONE : low_count_ff;

   // clamp wide counts to the 32-bit report
   if (COUNT_WIDTH > OUT_W) begin : g_clamp
      assign high_over = |high_count_ff[COUNT_WIDTH-1:OUT_W];
      assign low_over  = |low_count_ff[COUNT_WIDTH-1:OUT_W];
      assign high_out  = high_over ? {OUT_W{1'b1}} : high_count_ff[OUT_W-1:0];
      assign low_out   = low_over ? {OUT_W{1'b1}} : low_count_ff[OUT_W-1:0];
   end else if (COUNT_WIDTH == OUT_W) begin : g_same
      assign high_over = 1'b0;
      assign low_over  = 1'b0;
      assign high_out  = high_count_ff;
      assign low_out   = low_count_ff;
   end else begin : g_extend
      assign high_over = 1'b0;
      assign low_over  = 1'b0;
      assign high_out  = {{(OUT_W-COUNT_WIDTH){1'b0}}, high_count_ff};
      assign low_out   = {{(OUT_W-COUNT_WIDTH){1'b0}}, low_count_ff};
   end

   assign phase_low         = (phase_ff == PHASE_LOW);
   assign launch.emit       = accept && (phase_ff == PHASE_LOW) && pin_level;
   assign launch.high_ticks = high_out;
   assign launch.low_ticks  = low_out;
   assign launch.saturated  = mark_ff || high_over || low_over;

   always_comb begin
      phase_in      = phase_ff;
      prev_level_in = prev_level_ff;
      high_count_in = high_count_ff;
      low_count_in  = low_count_ff;
      mark_in       = mark_ff;
      if (accept) begin
         prev_level_in = pin_level;
         unique case (phase_ff)
            PHASE_HIGH: begin
               if (pin_level) begin
                  high_count_in = high_bump;
                  if (high_bump == COUNT_MAX) begin
                     mark_in = 1'b1;
                  end
               end else begin
                  low_count_in = COUNT_ONE;
                  phase_in     = PHASE_LOW;
               end
            end
            PHASE_LOW: begin
               if (!pin_level) begin
                  low_count_in = low_bump;
                  if (low_bump == COUNT_MAX) begin
                     mark_in = 1'b1;
                  end
               end else begin
                  phase_in = PHASE_WAIT;
               end
            end
            default: begin
               // open a measurement on a rising edge only
               if (!prev_level_ff && pin_level) begin
                  mark_in       = 1'b0;
                  high_count_in = COUNT_ONE;
                  low_count_in  = '0;
                  phase_in      = PHASE_HIGH;
               end else begin
                  phase_in = PHASE_WAIT;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_WAIT;
         prev_level_ff <= 1'b1;
         high_count_ff <= '0;
         low_count_ff  <= '0;
         mark_ff       <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         prev_level_ff <= prev_level_in;
         high_count_ff <= high_count_in;
         low_count_ff  <= low_count_in;
         mark_ff       <= mark_in;
      end
   end

endmodule

FILE: sv/pdfm_serial_divider.sv
// Restoring divider that retires one quotient bit per cycle.
// Depends on pdfm_pkg only through the shared import convention.
module pdfm_serial_divider
   import pdfm_pkg::*;
#(
   parameter int DIVIDEND_WIDTH = 39,
   parameter int DIVISOR_WIDTH  = 33
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [DIVIDEND_WIDTH-1:0] dividend,
   input  logic [DIVISOR_WIDTH-1:0]  divisor,
   output logic                      busy,
   output logic [DIVIDEND_WIDTH-1:0] quotient
);

   localparam int CNT_W = (DIVIDEND_WIDTH > 1) ? $clog2(DIVIDEND_WIDTH) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_WIDTH - 1);

   logic                      busy_ff, busy_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [DIVIDEND_WIDTH-1:0] quot_ff, quot_in;
   logic [DIVISOR_WIDTH-1:0]  rem_ff, rem_in;
   logic [DIVISOR_WIDTH-1:0]  divisor_ff, divisor_in;
   logic [DIVISOR_WIDTH:0]    shifted, diff;
   logic                      fits;

   assign busy     = busy_ff;
   assign quotient = quot_ff;

   // bring in the next dividend bit and try one subtract
   assign shifted = {rem_ff, quot_ff[DIVIDEND_WIDTH-1]};
   assign fits    = shifted >= {1'b0, divisor_ff};
   assign diff    = shifted - {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      count_in   = count_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         quot_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         quot_in  = {quot_ff[DIVIDEND_WIDTH-2:0], fits};
         rem_in   = fits ? diff[DIVISOR_WIDTH-1:0] : shifted[DIVISOR_WIDTH-1:0];
         count_in = count_ff + CNT_W'(1);
         if (count_ff == CNT_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

endmodule

FILE: sv/pwm_duty_frequency_meter_core.sv
// Top level of the PWM duty and frequency meter: counters, dividers, result register.
// Depends on pdfm_pkg, pdfm_channels, pdfm_edge_counter and pdfm_serial_divider.
//
//   channel       dir  payload                                            handshake
//   req_channel   in   pin_level                                          valid/ready
//   rsp_channel   out  duty_percent frequency_hz high_ticks low_ticks sat valid/ready
//   csr_*         in   csr_write_data = tick_rate_hz                      write enable
//
// One pin sample is taken per cycle unless requests stall. The closing rising edge
// starts the result math: the period sum is registered in SUM, the scaling by 100
// feeds the bit-serial dividers in SCALE, and the result is registered when both
// are done and offered in SEND. Samples keep flowing meanwhile, and while the result
// waits, unless the counters reach the next period's low phase; then requests stall.
// Reset is synchronous and leaves the tick rate at 1000000 Hz; there is no clearing pass.
module pwm_duty_frequency_meter_core
   import pdfm_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   pdfm_req_if.sink          req_channel,
   pdfm_rsp_if.source        rsp_channel,
   input  logic              csr_write_enable,
   input  logic [RATE_W-1:0] csr_write_data
);

   pdfm_ctl_type          ctl_ff, ctl_in;
   logic [RATE_W-1:0]     tick_rate_ff, tick_rate_in;
   logic [OUT_W-1:0]      high_cap_ff, low_cap_ff;
   logic                  sat_cap_ff;
   logic [PERIOD_W-1:0]   period_ff;
   logic [TRIPLE_W-1:0]   triple_ff;
   logic                  period_zero_ff;
   logic [DUTY_W-1:0]     duty_ff;
   logic [RATE_W-1:0]     freq_ff;
   logic [OUT_W-1:0]      high_out_ff, low_out_ff;
   logic                  sat_out_ff;

   logic                  accept;
   logic                  phase_low;
   pdfm_launch_type       launch;
   logic                  start_div;
   logic                  load_rsp;
   logic                  duty_busy, freq_busy;
   logic [DUTY_DIVIDEND_W-1:0] duty_dividend;
   logic [DUTY_DIVIDEND_W-1:0] duty_quot;
   logic [RATE_W-1:0]     freq_quot;

   assign accept            = req_channel.valid && req_channel.ready;
   // a request in the low phase may close a period, so hold it while math is pending
   assign req_channel.ready = (ctl_ff == CTL_IDLE) || !phase_low;

   pdfm_edge_counter #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_counter (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .pin_level(req_channel.pin_level),
      .phase_low(phase_low),
      .launch   (launch)
   );

   // 100h = 96h + 4h, with 3h registered in the preceding SUM state
   assign duty_dividend = {triple_ff, 5'b0}
                        + {{(DUTY_DIVIDEND_W-OUT_W-2){1'b0}}, high_cap_ff, 2'b0};

   pdfm_serial_divider #(
      .DIVIDEND_WIDTH(DUTY_DIVIDEND_W),
      .DIVISOR_WIDTH (PERIOD_W)
   ) u_duty_div (
      .clock   (clock),
      .reset   (reset),
      .start   (start_div),
      .dividend(duty_dividend),
      .divisor (period_ff),
      .busy    (duty_busy),
      .quotient(duty_quot)
   );

   pdfm_serial_divider #(
      .DIVIDEND_WIDTH(RATE_W),
      .DIVISOR_WIDTH (PERIOD_W)
   ) u_freq_div (
      .clock   (clock),
      .reset   (reset),
      .start   (start_div),
      .dividend(tick_rate_ff),
      .divisor (period_ff),
      .busy    (freq_busy),
      .quotient(freq_quot)
   );

   // next state
   always_comb begin
      ctl_in = ctl_ff;
      unique case (ctl_ff)
         CTL_IDLE: begin
            if (launch.emit) begin
               ctl_in = CTL_SUM;
            end
         end
         CTL_SUM:   ctl_in = CTL_SCALE;
         CTL_SCALE: ctl_in = CTL_DIVIDE;
         CTL_DIVIDE: begin
            if (!duty_busy && !freq_busy) begin
               ctl_in = CTL_SEND;
            end
         end
         CTL_SEND: begin
            if (rsp_channel.ready) begin
               ctl_in = CTL_IDLE;
            end
         end
         default: ctl_in = CTL_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      start_div         = 1'b0;
      load_rsp          = 1'b0;
      rsp_channel.valid = 1'b0;
      unique case (ctl_ff)
         CTL_SCALE:  start_div = 1'b1;
         CTL_DIVIDE: load_rsp = !duty_busy && !freq_busy;
         CTL_SEND:   rsp_channel.valid = 1'b1;
         default: begin
         end
      endcase
   end

   assign tick_rate_in = csr_write_enable ? csr_write_data : tick_rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff       <= CTL_IDLE;
         tick_rate_ff <= RATE_RESET;
      end else begin
         ctl_ff       <= ctl_in;
         tick_rate_ff <= tick_rate_in;
      end
   end

   always_ff @(posedge clock) begin
      if (launch.emit && (ctl_ff == CTL_IDLE)) begin
         high_cap_ff <= launch.high_ticks;
         low_cap_ff  <= launch.low_ticks;
         sat_cap_ff  <= launch.saturated;
      end
      if (ctl_ff == CTL_SUM) begin
         period_ff <= {1'b0, high_cap_ff} + {1'b0, low_cap_ff};
         triple_ff <= {1'b0, high_cap_ff, 1'b0} + {2'b0, high_cap_ff};
      end
      if (ctl_ff == CTL_SCALE) begin
         period_zero_ff <= (period_ff == '0);
      end
      if (load_rsp) begin
         duty_ff     <= period_zero_ff ? '0 : duty_quot[DUTY_W-1:0];
         freq_ff     <= period_zero_ff ? '0 : freq_quot;
         high_out_ff <= high_cap_ff;
         low_out_ff  <= low_cap_ff;
         sat_out_ff  <= sat_cap_ff;
      end
   end

   assign rsp_channel.duty_percent    = duty_ff;
   assign rsp_channel.frequency_hz    = freq_ff;
   assign rsp_channel.high_ticks      = high_out_ff;
   assign rsp_channel.low_ticks       = low_out_ff;
   assign rsp_channel.count_saturated = sat_out_ff;

endmodule
